/* rtl/pim_pkg.sv */
// shared types, constants and helpers for the point-in-mesh ray parity block
// no dependencies; imported by every module of the block
package pim_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_FACES    = 1024;
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned FIDX_W       = $clog2(MAX_FACES);
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned MUL_W        = DIFF_W + 1;
  localparam int unsigned LO_W         = DIFF_W;
  localparam int unsigned ACC_W        = 104;
  localparam int unsigned PLIM_W       = 32;
  localparam int unsigned DLIM_W       = 16;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned STEP_W       = 5;

  // sequencer steps of the triangle test
  localparam logic [STEP_W-1:0] STEP_ADJUST = 5'd17;
  localparam logic [STEP_W-1:0] STEP_LIM_LO = 5'd18;
  localparam logic [STEP_W-1:0] STEP_LIM_HI = 5'd19;
  localparam logic [STEP_W-1:0] STEP_LAST   = 5'd21;

  typedef enum logic [1:0] {
    CMD_WR_VERTEX = 2'd0,
    CMD_WR_FACE   = 2'd1,
    CMD_QUERY     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_FACES_IN_USE   = 2'd0,
    CFG_PARALLEL_LIMIT = 2'd1,
    CFG_DISTANCE_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FACE_RD,
    ST_FACE_CHK,
    ST_VA,
    ST_VB,
    ST_VC,
    ST_TEST,
    ST_DONE
  } q_state_e;

  typedef enum logic [2:0] {
    DST_DET,
    DST_U,
    DST_QX,
    DST_QY,
    DST_QZ,
    DST_E,
    DST_LIM
  } acc_dest_e;

  typedef struct packed {
    logic [1:0]                command;
    logic [FIDX_W-1:0]         slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [VIDX_W-1:0]         corner_a;
    logic [VIDX_W-1:0]         corner_b;
    logic [VIDX_W-1:0]         corner_c;
    logic                      face_valid;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } res_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [VIDX_W-1:0] a;
    logic [VIDX_W-1:0] b;
    logic [VIDX_W-1:0] c;
    logic              valid;
  } face_t;

  typedef struct packed {
    vec_t p;
    vec_t v0;
    vec_t v1;
    vec_t v2;
  } tri_req_t;

  typedef struct packed {
    logic      vld;
    acc_dest_e dest;
    logic      sub;
    logic      sh;
    logic      first;
  } mul_ctl_t;

  function automatic logic signed [DIFF_W-1:0] diff(logic signed [COORD_W-1:0] a,
                                                      logic signed [COORD_W-1:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_d(logic signed [DIFF_W-1:0] v);
    return {v[DIFF_W-1], v};
  endfunction

  // a wide value is split as hi * 2^LO_W + lo, lo unsigned
  function automatic logic signed [MUL_W-1:0] lo_part(logic signed [ACC_W-1:0] v);
    return {1'b0, v[LO_W-1:0]};
  endfunction

  function automatic logic signed [MUL_W-1:0] hi_part(logic signed [ACC_W-1:0] v);
    return v[LO_W+MUL_W-1:LO_W];
  endfunction

endpackage

/* rtl/pim_mesh_store.sv */
// vertex and face memories, one write and one registered read port each
// depends on pim_pkg
module pim_mesh_store import pim_pkg::*; (
  input  logic              clk_i,
  input  logic              v_we_i,
  input  logic [VIDX_W-1:0] v_waddr_i,
  input  vec_t              v_wdata_i,
  input  logic              v_re_i,
  input  logic [VIDX_W-1:0] v_raddr_i,
  output vec_t              v_rdata_o,
  input  logic              f_we_i,
  input  logic [FIDX_W-1:0] f_waddr_i,
  input  face_t             f_wdata_i,
  input  logic              f_re_i,
  input  logic [FIDX_W-1:0] f_raddr_i,
  output face_t             f_rdata_o
);

  vec_t  vmem [MAX_VERTICES];
  face_t fmem [MAX_FACES];
  vec_t  v_rdata_q;
  face_t f_rdata_q;

  always_ff @(posedge clk_i) begin
    if (v_we_i) begin
      vmem[v_waddr_i] <= v_wdata_i;
    end
    if (v_re_i) begin
      v_rdata_q <= vmem[v_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_we_i) begin
      fmem[f_waddr_i] <= f_wdata_i;
    end
    if (f_re_i) begin
      f_rdata_q <= fmem[f_raddr_i];
    end
  end

  assign v_rdata_o = v_rdata_q;
  assign f_rdata_o = f_rdata_q;

endmodule

/* rtl/pim_tri_test.sv */
// exact ray (+x) versus triangle test, sequenced over one shared 34x34 multiplier
// depends on pim_pkg
module pim_tri_test import pim_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tri_req_t          req_i,
  input  logic [PLIM_W-1:0] plim_i,
  input  logic [DLIM_W-1:0] dlim_i,
  output logic              done_o,
  output logic              hit_o
);

  logic                     run_q, run_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     done_q, done_d;
  logic                     hit_q, hit_d;
  logic signed [DIFF_W-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [DIFF_W-1:0] sx_q, sy_q, sz_q;
  logic signed [ACC_W-1:0]  det_q, u_q, qx_q, qy_q, qz_q, e_q, lim_q, sum_q;
  logic signed [ACC_W-1:0]  det_d, u_d, qx_d, qy_d, qz_d, e_d, lim_d, sum_d;
  logic signed [2*MUL_W-1:0] prod_q;
  mul_ctl_t                 ctl_q, iss;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0]  pe, addend, cur, nv, plim_ext, dl_ext;

  assign dl_ext   = {{(ACC_W-DLIM_W){1'b0}}, dlim_i};
  assign plim_ext = {{(ACC_W-PLIM_W){1'b0}}, plim_i};

  // multiply issue table
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    iss   = '{vld: 1'b0, dest: DST_DET, sub: 1'b0, sh: 1'b0, first: 1'b0};
    if (run_q) begin
      case (step_q)
        5'd0: begin
          mul_a = ext_d(e1z_q); mul_b = ext_d(e2y_q);
          iss = '{vld: 1'b1, dest: DST_DET, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd1: begin
          mul_a = ext_d(e1y_q); mul_b = ext_d(e2z_q);
          iss = '{vld: 1'b1, dest: DST_DET, sub: 1'b1, sh: 1'b0, first: 1'b0};
        end
        5'd2: begin
          mul_a = ext_d(sz_q); mul_b = ext_d(e2y_q);
          iss = '{vld: 1'b1, dest: DST_U, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd3: begin
          mul_a = ext_d(sy_q); mul_b = ext_d(e2z_q);
          iss = '{vld: 1'b1, dest: DST_U, sub: 1'b1, sh: 1'b0, first: 1'b0};
        end
        5'd4: begin
          mul_a = ext_d(sy_q); mul_b = ext_d(e1z_q);
          iss = '{vld: 1'b1, dest: DST_QX, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd5: begin
          mul_a = ext_d(sz_q); mul_b = ext_d(e1y_q);
          iss = '{vld: 1'b1, dest: DST_QX, sub: 1'b1, sh: 1'b0, first: 1'b0};
        end
        5'd6: begin
          mul_a = ext_d(sz_q); mul_b = ext_d(e1x_q);
          iss = '{vld: 1'b1, dest: DST_QY, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd7: begin
          mul_a = ext_d(sx_q); mul_b = ext_d(e1z_q);
          iss = '{vld: 1'b1, dest: DST_QY, sub: 1'b1, sh: 1'b0, first: 1'b0};
        end
        5'd8: begin
          mul_a = ext_d(sx_q); mul_b = ext_d(e1y_q);
          iss = '{vld: 1'b1, dest: DST_QZ, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd9: begin
          mul_a = ext_d(sy_q); mul_b = ext_d(e1x_q);
          iss = '{vld: 1'b1, dest: DST_QZ, sub: 1'b1, sh: 1'b0, first: 1'b0};
        end
        5'd10: begin
          mul_a = ext_d(e2x_q); mul_b = lo_part(qx_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        5'd11: begin
          mul_a = ext_d(e2x_q); mul_b = hi_part(qx_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b1, first: 1'b0};
        end
        5'd12: begin
          mul_a = ext_d(e2y_q); mul_b = lo_part(qy_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b0, first: 1'b0};
        end
        5'd13: begin
          mul_a = ext_d(e2y_q); mul_b = hi_part(qy_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b1, first: 1'b0};
        end
        5'd14: begin
          mul_a = ext_d(e2z_q); mul_b = lo_part(qz_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b0, first: 1'b0};
        end
        5'd15: begin
          mul_a = ext_d(e2z_q); mul_b = hi_part(qz_q);
          iss = '{vld: 1'b1, dest: DST_E, sub: 1'b0, sh: 1'b1, first: 1'b0};
        end
        STEP_LIM_LO: begin
          mul_a = dl_ext[MUL_W-1:0]; mul_b = lo_part(det_q);
          iss = '{vld: 1'b1, dest: DST_LIM, sub: 1'b0, sh: 1'b0, first: 1'b1};
        end
        STEP_LIM_HI: begin
          mul_a = dl_ext[MUL_W-1:0]; mul_b = hi_part(det_q);
          iss = '{vld: 1'b1, dest: DST_LIM, sub: 1'b0, sh: 1'b1, first: 1'b0};
        end
        default: ;
      endcase
    end
  end

  // accumulate the registered product into its destination
  always_comb begin
    pe     = {{(ACC_W-2*MUL_W){prod_q[2*MUL_W-1]}}, prod_q};
    addend = ctl_q.sh ? (pe <<< LO_W) : pe;
    case (ctl_q.dest)
      DST_DET: cur = det_q;
      DST_U:   cur = u_q;
      DST_QX:  cur = qx_q;
      DST_QY:  cur = qy_q;
      DST_QZ:  cur = qz_q;
      DST_E:   cur = e_q;
      DST_LIM: cur = lim_q;
      default: cur = '0;
    endcase
    if (ctl_q.first) begin
      cur = '0;
    end
    nv = ctl_q.sub ? (cur - addend) : (cur + addend);

    det_d = det_q; u_d = u_q; qx_d = qx_q; qy_d = qy_q;
    qz_d = qz_q; e_d = e_q; lim_d = lim_q; sum_d = sum_q;
    if (ctl_q.vld) begin
      case (ctl_q.dest)
        DST_DET: det_d = nv;
        DST_U:   u_d   = nv;
        DST_QX:  qx_d  = nv;
        DST_QY:  qy_d  = nv;
        DST_QZ:  qz_d  = nv;
        DST_E:   e_d   = nv;
        DST_LIM: lim_d = nv;
        default: ;
      endcase
    end
    // make det positive and flip the sign-carrying terms with it
    if (run_q && step_q == STEP_ADJUST && det_q < 0) begin
      det_d = -det_q;
      u_d   = -u_q;
      qx_d  = -qx_q;
      e_d   = -e_q;
    end
    if (run_q && step_q == STEP_LIM_LO) begin
      sum_d = u_q + qx_q;
    end
  end

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    done_d = 1'b0;
    hit_d  = hit_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (run_q) begin
      step_d = step_q + 1'b1;
      if (step_q == STEP_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        hit_d  = (det_q != 0) && !(det_q < plim_ext) && !(u_q < 0) && !(det_q < u_q) &&
                 !(qx_q < 0) && !(det_q < sum_q) && (lim_q < e_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      ctl_q  <= '{vld: 1'b0, dest: DST_DET, sub: 1'b0, sh: 1'b0, first: 1'b0};
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      done_q <= done_d;
      hit_q  <= hit_d;
      ctl_q  <= iss;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e1x_q <= diff(req_i.v1.x, req_i.v0.x);
      e1y_q <= diff(req_i.v1.y, req_i.v0.y);
      e1z_q <= diff(req_i.v1.z, req_i.v0.z);
      e2x_q <= diff(req_i.v2.x, req_i.v0.x);
      e2y_q <= diff(req_i.v2.y, req_i.v0.y);
      e2z_q <= diff(req_i.v2.z, req_i.v0.z);
      sx_q  <= diff(req_i.p.x, req_i.v0.x);
      sy_q  <= diff(req_i.p.y, req_i.v0.y);
      sz_q  <= diff(req_i.p.z, req_i.v0.z);
    end
    prod_q <= mul_a * mul_b;
    det_q  <= det_d;
    u_q    <= u_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    qz_q   <= qz_d;
    e_q    <= e_d;
    lim_q  <= lim_d;
    sum_q  <= sum_d;
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

/* rtl/point_in_mesh_ray_parity.sv */
// top level: command decode, query sequencer over the face list, config registers
// depends on pim_pkg, pim_mesh_store and pim_tri_test
//
// usage: an item is taken when start_i is high and busy_o is low. command 0 writes
// a vertex into slot, command 1 writes a face (three corner indices and a valid
// mark); both give no result and leave busy_o low. command 3 is dropped. command 2
// casts a ray along +x from the point and raises busy_o until its result appears.
// each result sits on res_o for exactly one cycle with res_valid_o high; the
// receiver cannot stall, so nothing is held back.
// a query walks face slots 0 .. faces_in_use-1 (capped at 1024). an invalid face
// costs a face memory read and check; a valid one adds vertex memory reads on
// single read ports and the triangle test, which runs its 18 products one per
// cycle through a shared 34x34 multiplier. the result is on res_o in the cycle
// after the last face; an empty face list answers in the cycle right after the
// item is taken. busy_o drops in the cycle after the result.
// config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and belong
// to idle time. reset sets faces_in_use 0, parallel_limit 4295, distance_limit 0
// and idles the sequencer; the memories are not cleared.
module point_in_mesh_ray_parity import pim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  in_item_t         in_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output res_item_t        res_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  q_state_e          state_q, state_d;
  logic [CNT_W-1:0]  fiu_q;
  logic [PLIM_W-1:0] plim_q;
  logic [DLIM_W-1:0] dlim_q;
  logic [CNT_W-1:0]  idx_q, idx_d, nfaces_q, nfaces_d, count_q, count_d;
  logic [CNT_W-1:0]  idx_inc, fiu_sat;
  vec_t              point_q, v0_q, v1_q;
  logic              take, v_re, f_re, tri_start, tri_done, tri_hit;
  logic [VIDX_W-1:0] v_raddr;
  vec_t              v_rdata, v_wdata;
  face_t             f_rdata, f_wdata;
  tri_req_t          tri_req;

  assign take    = start_i && !busy_o;
  assign idx_inc = idx_q + 1'b1;
  assign fiu_sat = (fiu_q > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES) : fiu_q;
  assign v_wdata = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};
  assign f_wdata = '{a: in_i.corner_a, b: in_i.corner_b, c: in_i.corner_c,
                     valid: in_i.face_valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q  <= '0;
      plim_q <= PLIM_W'(4295);
      dlim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FACES_IN_USE:   fiu_q  <= cfg_data_i[CNT_W-1:0];
        CFG_PARALLEL_LIMIT: plim_q <= cfg_data_i[PLIM_W-1:0];
        CFG_DISTANCE_LIMIT: dlim_q <= cfg_data_i[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    nfaces_d = nfaces_q;
    count_d  = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && in_i.command == CMD_QUERY) begin
          idx_d    = '0;
          count_d  = '0;
          nfaces_d = fiu_sat;
          state_d  = (fiu_sat == '0) ? ST_DONE : ST_FACE_RD;
        end
      end
      ST_FACE_RD: state_d = ST_FACE_CHK;
      ST_FACE_CHK: begin
        if (f_rdata.valid) begin
          state_d = ST_VA;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == nfaces_q) ? ST_DONE : ST_FACE_RD;
        end
      end
      ST_VA: state_d = ST_VB;
      ST_VB: state_d = ST_VC;
      ST_VC: state_d = ST_TEST;
      ST_TEST: begin
        if (tri_done) begin
          if (tri_hit) begin
            count_d = count_q + 1'b1;
          end
          idx_d   = idx_inc;
          state_d = (idx_inc == nfaces_q) ? ST_DONE : ST_FACE_RD;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    f_re        = 1'b0;
    v_re        = 1'b0;
    v_raddr     = f_rdata.a;
    tri_start   = 1'b0;
    unique case (state_q)
      ST_IDLE:     busy_o = 1'b0;
      ST_FACE_RD:  f_re = 1'b1;
      ST_FACE_CHK: v_re = f_rdata.valid;
      ST_VA: begin
        v_re    = 1'b1;
        v_raddr = f_rdata.b;
      end
      ST_VB: begin
        v_re    = 1'b1;
        v_raddr = f_rdata.c;
      end
      ST_VC:   tri_start = 1'b1;
      ST_TEST: ;
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o   = '{inside_res: count_q[0], crossing_count: count_q};
  assign tri_req = '{p: point_q, v0: v0_q, v1: v1_q, v2: v_rdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      nfaces_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      nfaces_q <= nfaces_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && take) begin
      point_q <= v_wdata;
    end
    if (state_q == ST_VA) begin
      v0_q <= v_rdata;
    end
    if (state_q == ST_VB) begin
      v1_q <= v_rdata;
    end
  end

  pim_mesh_store u_store (
    .clk_i     (clk_i),
    .v_we_i    (take && in_i.command == CMD_WR_VERTEX),
    .v_waddr_i (in_i.slot),
    .v_wdata_i (v_wdata),
    .v_re_i    (v_re),
    .v_raddr_i (v_raddr),
    .v_rdata_o (v_rdata),
    .f_we_i    (take && in_i.command == CMD_WR_FACE),
    .f_waddr_i (in_i.slot),
    .f_wdata_i (f_wdata),
    .f_re_i    (f_re),
    .f_raddr_i (idx_q[FIDX_W-1:0]),
    .f_rdata_o (f_rdata)
  );

  pim_tri_test u_tri (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tri_start),
    .req_i   (tri_req),
    .plim_i  (plim_q),
    .dlim_i  (dlim_q),
    .done_o  (tri_done),
    .hit_o   (tri_hit)
  );

endmodule
